/* hw/rtl/pfles_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfles_pkg
// Shared widths, constants and control types of the per-flow loss and
// departure-time shaper.
// ----------------------------------------------------------------------------
package pfles_pkg;

   localparam int FLOW_W     = 10;
   localparam int LEN_W      = 16;
   localparam int TIME_W     = 64;
   localparam int RATE_W     = 32;
   localparam int LOSS_W     = 8;
   localparam int HZN_W      = 32;
   localparam int CNT_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int DVD_W      = 64;
   localparam int DSR_W      = 32;
   localparam int STEP_W     = 7;
   localparam int PCT_W      = 7;
   localparam int NS_W       = 30;

   localparam logic [NS_W-1:0]   SEC_TO_NS      = 30'd1000000000;
   localparam logic [PCT_W-1:0]  PERCENT_FULL   = 7'd100;
   localparam logic [HZN_W-1:0]  DROP_HZN_RESET = 32'd2000000000;
   localparam logic [HZN_W-1:0]  ECN_HZN_RESET  = 32'd500000000;

   localparam logic [STEP_W-1:0] QUOT_STEPS = 7'd7;
   localparam logic [STEP_W-1:0] CNT_STEPS  = 7'd32;
   localparam logic [STEP_W-1:0] GAP_STEPS  = 7'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DROP_HZN = 1'b0,
      CSR_ECN_HZN  = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      DIV_QUOT,
      DIV_CNT,
      DIV_GAP
   } div_sel_type;

   typedef enum logic [1:0] {
      RES_PASS,
      RES_DROP,
      RES_EVAL
   } res_kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_FLOW_WAIT,
      ST_READ,
      ST_LOSS,
      ST_QUOT_WAIT,
      ST_CNT_WAIT,
      ST_RATE,
      ST_GAP_START,
      ST_GAP_WAIT,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic         capture;
      logic         clr_write;
      logic         div_start;
      div_sel_type  div_sel;
      logic         flow_quo;
      logic         flow_latch;
      logic         mem_read;
      logic         cnt_write;
      logic         mul_load;
      logic         next_load;
      logic         res_set;
      res_kind_type res_kind;
      logic         dep_write;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic eligible;
      logic loss_zero;
      logic loss_full;
      logic cnt_hit;
      logic rate_zero;
      logic div_done;
      logic out_full;
      logic clr_last;
   } status_type;

endpackage

/* hw/rtl/pfles_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfles_req_if / pfles_rsp_if
// Valid/ready channels for packet events and shaping verdicts.
// ----------------------------------------------------------------------------
interface pfles_req_if;
   import pfles_pkg::*;
   logic                valid;
   logic                ready;
   logic                eligible;
   logic [FLOW_W-1:0]   flow_index;
   logic [LEN_W-1:0]    packet_length;
   logic [TIME_W-1:0]   packet_time;
   logic [TIME_W-1:0]   current_time;
   logic [RATE_W-1:0]   rate_bytes_per_sec;
   logic [LOSS_W-1:0]   loss_pct;
   modport source (output valid, eligible, flow_index, packet_length, packet_time,
                   current_time, rate_bytes_per_sec, loss_pct, input ready);
   modport sink (input valid, eligible, flow_index, packet_length, packet_time,
                 current_time, rate_bytes_per_sec, loss_pct, output ready);
endinterface

interface pfles_rsp_if;
   import pfles_pkg::*;
   logic              valid;
   logic              ready;
   logic              drop;
   logic [TIME_W-1:0] departure_time;
   logic              ecn_mark;
   modport source (output valid, drop, departure_time, ecn_mark, input ready);
   modport sink (input valid, drop, departure_time, ecn_mark, output ready);
endinterface

/* hw/rtl/per_flow_loss_and_edt_shaper_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_flow_loss_and_edt_shaper_unit
// Per-flow deterministic loss and earliest-departure-time rate shaper.
// ----------------------------------------------------------------------------
// One packet event is handled at a time and gives one verdict. An ineligible
// packet goes from CHECK straight to FINISH; a throttled packet with loss
// enabled also runs the shared bit-serial divider (7 and 32 steps for the loss
// period and remainder, 64 for the rate gap), and any packet waits in FINISH
// while the previous verdict is still not taken by rsp ready. After reset
// the block sweeps every entry of its flow tables before taking the first
// event; configuration writes are taken throughout. A finished verdict
// waits in an output register while the next event is accepted.
module per_flow_loss_and_edt_shaper_unit #(
   parameter int FLOWS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   pfles_req_if.sink                          req_chan,
   pfles_rsp_if.source                        rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [pfles_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfles_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import pfles_pkg::*;

   cmd_type    cmd;
   status_type stat;
   logic       in_ready;

   assign req_chan.ready = in_ready;

   pfles_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .in_ready  (in_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfles_dp #(
      .FLOWS (FLOWS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .req_eligible           (req_chan.eligible),
      .req_flow_index         (req_chan.flow_index),
      .req_packet_length      (req_chan.packet_length),
      .req_packet_time        (req_chan.packet_time),
      .req_current_time       (req_chan.current_time),
      .req_rate_bytes_per_sec (req_chan.rate_bytes_per_sec),
      .req_loss_pct           (req_chan.loss_pct),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .rsp_ready              (rsp_chan.ready),
      .rsp_valid              (rsp_chan.valid),
      .rsp_drop               (rsp_chan.drop),
      .rsp_departure_time     (rsp_chan.departure_time),
      .rsp_ecn_mark           (rsp_chan.ecn_mark)
   );

endmodule

/* hw/rtl/pfles_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfles_div
// Restoring divider, one quotient bit per cycle, MSB-aligned dividend.
// ----------------------------------------------------------------------------
module pfles_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pfles_pkg::DVD_W-1:0]      dvd,
   input  logic [pfles_pkg::DSR_W-1:0]      dsr,
   input  logic [pfles_pkg::STEP_W-1:0]     steps,
   output logic                             busy,
   output logic [pfles_pkg::DVD_W-1:0]      quo,
   output logic [pfles_pkg::DSR_W-1:0]      rem
);
   import pfles_pkg::*;

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [DVD_W-1:0]    dvd_ff, dvd_in;
   logic [DSR_W-1:0]    dsr_ff, dsr_in;
   logic [DVD_W-1:0]    quo_ff, quo_in;
   logic [DSR_W-1:0]    rem_ff, rem_in;
   logic [DSR_W:0]      rem_sh;
   logic [DSR_W:0]      rem_sub;
   logic                ge;

   assign rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge      = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         dvd_in  = dvd;
         dsr_in  = dsr;
         quo_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in  = {quo_ff[DVD_W-2:0], ge};
         rem_in  = ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

/* hw/rtl/pfles_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfles_dp
// Datapath: flow state memories, loss counter, gap arithmetic, horizon
// checks, configuration registers and the result register.
// ----------------------------------------------------------------------------
module pfles_dp #(
   parameter int FLOWS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pfles_pkg::cmd_type                    cmd,
   output pfles_pkg::status_type                 stat,
   input  logic                                  req_eligible,
   input  logic [pfles_pkg::FLOW_W-1:0]          req_flow_index,
   input  logic [pfles_pkg::LEN_W-1:0]           req_packet_length,
   input  logic [pfles_pkg::TIME_W-1:0]          req_packet_time,
   input  logic [pfles_pkg::TIME_W-1:0]          req_current_time,
   input  logic [pfles_pkg::RATE_W-1:0]          req_rate_bytes_per_sec,
   input  logic [pfles_pkg::LOSS_W-1:0]          req_loss_pct,
   input  logic                                  csr_write_enable,
   input  logic [pfles_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pfles_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic                                  rsp_drop,
   output logic [pfles_pkg::TIME_W-1:0]          rsp_departure_time,
   output logic                                  rsp_ecn_mark
);
   import pfles_pkg::*;

   localparam int FIDX_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;
   localparam logic [FIDX_W-1:0] CLR_LAST  = FIDX_W'(FLOWS - 1);
   // flow slot modulo by reciprocal multiply, exact for 10-bit indexes
   localparam int RCP_SH = 26;
   localparam int FK_W   = 17;
   localparam int FQ_W   = FLOW_W + FK_W;
   localparam logic [RCP_SH-1:0] FLOW_RCP =
      RCP_SH'(((64'd1 << RCP_SH) + 64'(FLOWS - 1)) / 64'(FLOWS));
   localparam logic [FK_W-1:0]   FLOWS_K  = FK_W'(FLOWS);

   // captured request
   logic                eligible_ff;
   logic [FLOW_W-1:0]   flow_raw_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [TIME_W-1:0]   ts_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [RATE_W-1:0]   rate_ff;
   logic [LOSS_W-1:0]   loss_ff;

   logic [HZN_W-1:0]    drop_hzn_ff;
   logic [HZN_W-1:0]    ecn_hzn_ff;

   logic [FIDX_W-1:0]   flow_ff;
   logic [FIDX_W-1:0]   clr_ff;

   logic [FLOW_W+RCP_SH-1:0] flow_prod;
   logic [FLOW_W-1:0]        flow_quo_ff;
   logic [FQ_W-1:0]          flow_sub;

   logic [CNT_W:0]      cnt_mem [FLOWS];
   logic [TIME_W:0]     dep_mem [FLOWS];
   logic [CNT_W:0]      cnt_rd_ff;
   logic [TIME_W:0]     dep_rd_ff;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic [LEN_W+NS_W-1:0] prod_w;
   logic [TIME_W-1:0]   prod_ff;
   logic [TIME_W-1:0]   next_ff, next_in;
   logic [TIME_W-1:0]   t_ff, t_in;

   logic                res_drop_ff, res_drop_in;
   logic [TIME_W-1:0]   res_time_ff, res_time_in;
   logic                res_ecn_ff, res_ecn_in;

   logic                out_valid_ff;
   logic                out_drop_ff;
   logic [TIME_W-1:0]   out_time_ff;
   logic                out_ecn_ff;

   logic                div_start;
   logic [DVD_W-1:0]    div_dvd;
   logic [DSR_W-1:0]    div_dsr;
   logic [STEP_W-1:0]   div_steps;
   logic                div_busy;
   logic [DVD_W-1:0]    div_quo;
   logic [DSR_W-1:0]    div_rem;

   logic                send_now;
   logic [TIME_W-1:0]   wait_ns;
   logic                past_drop;
   logic                past_ecn;

   // divider operand select
   always_comb begin
      unique case (cmd.div_sel)
         DIV_QUOT: begin
            div_dvd   = {PERCENT_FULL, {(DVD_W-PCT_W){1'b0}}};
            div_dsr   = {{(DSR_W-LOSS_W){1'b0}}, loss_ff};
            div_steps = QUOT_STEPS;
         end
         DIV_CNT: begin
            div_dvd   = {count_ff, {(DVD_W-CNT_W){1'b0}}};
            div_dsr   = div_quo[DSR_W-1:0];
            div_steps = CNT_STEPS;
         end
         DIV_GAP: begin
            div_dvd   = prod_ff;
            div_dsr   = rate_ff;
            div_steps = GAP_STEPS;
         end
         default: begin
            div_dvd   = prod_ff;
            div_dsr   = rate_ff;
            div_steps = GAP_STEPS;
         end
      endcase
   end

   assign div_start = cmd.div_start;

   pfles_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .dvd   (div_dvd),
      .dsr   (div_dsr),
      .steps (div_steps),
      .busy  (div_busy),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   assign flow_prod = {{RCP_SH{1'b0}}, flow_raw_ff} * {{FLOW_W{1'b0}}, FLOW_RCP};
   assign flow_sub  = {{FK_W{1'b0}}, flow_raw_ff} -
                      ({{FK_W{1'b0}}, flow_quo_ff} * {{FLOW_W{1'b0}}, FLOWS_K});
   assign prod_w    = {{NS_W{1'b0}}, len_ff} * {{LEN_W{1'b0}}, SEC_TO_NS};

   assign count_in = cnt_rd_ff[CNT_W] ? cnt_rd_ff[CNT_W-1:0] + 1'b1 : '0;
   assign next_in  = dep_rd_ff[TIME_W] ? dep_rd_ff[TIME_W-1:0] + div_quo : '0;
   assign t_in     = (ts_ff < now_ff) ? now_ff : ts_ff;

   assign send_now  = next_ff <= t_ff;
   assign wait_ns   = next_ff - now_ff;
   assign past_drop = wait_ns >= {{(TIME_W-HZN_W){1'b0}}, drop_hzn_ff};
   assign past_ecn  = wait_ns >= {{(TIME_W-HZN_W){1'b0}}, ecn_hzn_ff};

   always_comb begin
      res_drop_in = 1'b0;
      res_time_in = ts_ff;
      res_ecn_in  = 1'b0;
      unique case (cmd.res_kind)
         RES_PASS: ;
         RES_DROP: res_drop_in = 1'b1;
         RES_EVAL: begin
            priority if (send_now) begin
               res_time_in = t_ff;
            end else if (past_drop) begin
               res_drop_in = 1'b1;
            end else begin
               res_time_in = next_ff;
               res_ecn_in  = past_ecn;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_hzn_ff  <= DROP_HZN_RESET;
         ecn_hzn_ff   <= ECN_HZN_RESET;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_idx_type'(csr_index))
               CSR_DROP_HZN: drop_hzn_ff <= csr_write_data;
               CSR_ECN_HZN:  ecn_hzn_ff  <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.clr_write) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         eligible_ff <= req_eligible;
         flow_raw_ff <= req_flow_index;
         len_ff      <= req_packet_length;
         ts_ff       <= req_packet_time;
         now_ff      <= req_current_time;
         rate_ff     <= req_rate_bytes_per_sec;
         loss_ff     <= req_loss_pct;
      end
      if (cmd.flow_quo) begin
         flow_quo_ff <= flow_prod[FLOW_W+RCP_SH-1:RCP_SH];
      end
      if (cmd.flow_latch) begin
         flow_ff <= FIDX_W'(flow_sub[FLOW_W-1:0]);
      end
      if (cmd.cnt_write) begin
         count_ff <= count_in;
      end
      if (cmd.mul_load) begin
         prod_ff <= {{(TIME_W-LEN_W-NS_W){1'b0}}, prod_w};
      end
      if (cmd.next_load) begin
         next_ff <= next_in;
         t_ff    <= t_in;
      end
      if (cmd.res_set) begin
         res_drop_ff <= res_drop_in;
         res_time_ff <= res_time_in;
         res_ecn_ff  <= res_ecn_in;
      end
      if (cmd.out_load) begin
         out_drop_ff <= res_drop_ff;
         out_time_ff <= res_time_ff;
         out_ecn_ff  <= res_ecn_ff;
      end
   end

   // flow state memories
   always_ff @(posedge clock) begin
      if (cmd.clr_write) begin
         cnt_mem[clr_ff] <= '0;
      end else if (cmd.cnt_write) begin
         cnt_mem[flow_ff] <= {1'b1, count_in};
      end
      if (cmd.mem_read) begin
         cnt_rd_ff <= cnt_mem[flow_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_write) begin
         dep_mem[clr_ff] <= '0;
      end else if (cmd.dep_write && (send_now || !past_drop)) begin
         dep_mem[flow_ff] <= {1'b1, send_now ? t_ff : next_ff};
      end
      if (cmd.mem_read) begin
         dep_rd_ff <= dep_mem[flow_ff];
      end
   end

   assign stat.eligible  = eligible_ff;
   assign stat.loss_zero = (loss_ff == '0);
   assign stat.loss_full = (loss_ff >= {1'b0, PERCENT_FULL});
   assign stat.cnt_hit   = (div_rem == '0);
   assign stat.rate_zero = (rate_ff == '0);
   assign stat.div_done  = !div_busy;
   assign stat.out_full  = out_valid_ff && !rsp_ready;
   assign stat.clr_last  = (clr_ff == CLR_LAST);

   assign rsp_valid          = out_valid_ff;
   assign rsp_drop           = out_drop_ff;
   assign rsp_departure_time = out_time_ff;
   assign rsp_ecn_mark       = out_ecn_ff;

endmodule

/* hw/rtl/pfles_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfles_ctrl
// Sequencer: steps one packet event through loss, gap division and the
// horizon decision.
// ----------------------------------------------------------------------------
module pfles_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    in_ready,
   input  pfles_pkg::status_type   stat,
   output pfles_pkg::cmd_type      cmd
);
   import pfles_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (stat.clr_last) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid) state_in = ST_CHECK;
         ST_CHECK:     state_in = stat.eligible ? ST_FLOW_WAIT : ST_FINISH;
         ST_FLOW_WAIT: state_in = ST_READ;
         ST_READ:      state_in = ST_LOSS;
         ST_LOSS: begin
            priority if (stat.loss_zero) state_in = ST_RATE;
            else if (stat.loss_full)     state_in = ST_FINISH;
            else                         state_in = ST_QUOT_WAIT;
         end
         ST_QUOT_WAIT: if (stat.div_done) state_in = ST_CNT_WAIT;
         ST_CNT_WAIT: begin
            if (stat.div_done) state_in = stat.cnt_hit ? ST_FINISH : ST_RATE;
         end
         ST_RATE:      state_in = stat.rate_zero ? ST_FINISH : ST_GAP_START;
         ST_GAP_START: state_in = ST_GAP_WAIT;
         ST_GAP_WAIT:  if (stat.div_done) state_in = ST_DECIDE;
         ST_DECIDE:    state_in = ST_FINISH;
         ST_FINISH:    if (!stat.out_full) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_write = 1'b1;
         ST_IDLE: begin
            in_ready    = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CHECK: begin
            if (stat.eligible) begin
               cmd.flow_quo = 1'b1;
            end else begin
               cmd.res_set  = 1'b1;
               cmd.res_kind = RES_PASS;
            end
         end
         ST_FLOW_WAIT: cmd.flow_latch = 1'b1;
         ST_READ:      cmd.mem_read = 1'b1;
         ST_LOSS: begin
            priority if (stat.loss_zero) begin
            end else if (stat.loss_full) begin
               cmd.res_set  = 1'b1;
               cmd.res_kind = RES_DROP;
            end else begin
               cmd.cnt_write = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_QUOT;
            end
         end
         ST_QUOT_WAIT: begin
            cmd.div_start = stat.div_done;
            cmd.div_sel   = DIV_CNT;
         end
         ST_CNT_WAIT: begin
            cmd.res_set  = stat.div_done && stat.cnt_hit;
            cmd.res_kind = RES_DROP;
         end
         ST_RATE: begin
            cmd.mul_load = !stat.rate_zero;
            cmd.res_set  = stat.rate_zero;
            cmd.res_kind = RES_PASS;
         end
         ST_GAP_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_GAP;
         end
         ST_GAP_WAIT: cmd.next_load = stat.div_done;
         ST_DECIDE: begin
            cmd.res_set   = 1'b1;
            cmd.res_kind  = RES_EVAL;
            cmd.dep_write = 1'b1;
         end
         ST_FINISH: cmd.out_load = !stat.out_full;
         default: ;
      endcase
   end

endmodule
